// File: hw/rtl/wtft_pkg.sv
`timescale 1ns / 1ps

package wtft_pkg;

  // Vector width default, Q16.16
  localparam int unsigned VECTOR_WIDTH_DEFAULT = 32;

  // Rotation entries: signed Q1.14, three to a 48-bit row
  localparam int unsigned ROT_COEF_W = 16;
  localparam int unsigned ROT_FRAC   = 14;
  localparam int unsigned ROT_ROW_W  = 3 * ROT_COEF_W;
  // Bits a rotated component gains over the input vector
  localparam int unsigned ROT_GROWTH = ROT_COEF_W + 2 - ROT_FRAC;

  // Translation: signed 20-bit per axis, units of 1/1024 m
  localparam int unsigned TRN_W      = 20;
  localparam int unsigned TRN_FRAC   = 10;
  localparam int unsigned TRN_VEC_W  = 3 * TRN_W;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = TRN_VEC_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_VECTOR_KIND = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROT_ROW_0   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROT_ROW_1   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROT_ROW_2   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSLATION = 3'd4;

  // Vector kind: force/torque or linear/angular velocity
  typedef enum logic {
    KIND_WRENCH = 1'b0,
    KIND_TWIST  = 1'b1
  } vector_kind_e;

  // Reset frame: identity rotation, zero offset
  localparam logic [ROT_ROW_W-1:0] ROT_ROW_0_RESET = 48'h0000_0000_4000;
  localparam logic [ROT_ROW_W-1:0] ROT_ROW_1_RESET = 48'h0000_4000_0000;
  localparam logic [ROT_ROW_W-1:0] ROT_ROW_2_RESET = 48'h4000_0000_0000;
  localparam logic [TRN_VEC_W-1:0] TRANSLATION_RESET = '0;

  // Stage enables of the rotation unit
  typedef struct packed {
    logic prod;
    logic sum;
  } rot_en_t;

endpackage

// File: hw/rtl/wtft_rotate.sv
`timescale 1ns / 1ps

// Two-stage rotation R * a: products, then row sums floored by 2^14.
module wtft_rotate import wtft_pkg::*; #(
  parameter int unsigned VECTOR_WIDTH = VECTOR_WIDTH_DEFAULT
) (
  input  logic                                      clk_i,
  input  rot_en_t                                   en_i,
  input  logic        [ROT_ROW_W-1:0]               rot_row_i [3],
  input  logic signed [VECTOR_WIDTH-1:0]            vec_i     [3],
  output logic signed [VECTOR_WIDTH+ROT_GROWTH-1:0] rot_o     [3]
);

  localparam int unsigned PW = VECTOR_WIDTH + ROT_COEF_W;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned RW = VECTOR_WIDTH + ROT_GROWTH;

  logic signed [PW-1:0] prod_d [3][3];
  logic signed [PW-1:0] prod_q [3][3];
  logic signed [SW-1:0] sum_d  [3];
  logic signed [RW-1:0] rot_q  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[r][k] = PW'($signed(rot_row_i[r][ROT_COEF_W*k +: ROT_COEF_W]))
                     * PW'(vec_i[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2]);
    end
  end

  // Drop the fraction bits: floor toward minus infinity
  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      for (int r = 0; r < 3; r++) begin
        rot_q[r] <= $signed(sum_d[r][SW-1:ROT_FRAC]);
      end
    end
  end

  assign rot_o = rot_q;

endmodule

// File: hw/rtl/wrench_twist_frame_transform_core.sv
`timescale 1ns / 1ps

// Channel   | Direction | Signals                                   | Handshake
// ----------+-----------+-------------------------------------------+----------------------------
// request   | in        | first_x/y/z_i, second_x/y/z_i             | start_i && !busy_o
// result    | out       | out_first_x/y/z_o, out_second_x/y/z_o,    | result_valid_o, one cycle
//           |           | saturated_o                               |
// config    | in        | cfg_index_i, cfg_data_i                   | cfg_we_i, no wait
//
// One request per cycle, sustained. A request taken at a clock edge passes through the five
// register stages in order and is then on the result ports; the stages are the rotation
// multiplies, the rotation row sums, the cross-product multiplies, the cross difference and
// the final add with saturation. busy_o stays low: the receiver cannot stall, so nothing in
// the pipe ever waits. Reset (rst_ni low, asynchronous) empties the pipe and loads the
// identity frame in wrench mode.
module wrench_twist_frame_transform_core import wtft_pkg::*; #(
  parameter int unsigned VECTOR_WIDTH = VECTOR_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [VECTOR_WIDTH-1:0] first_x_i,
  input  logic signed [VECTOR_WIDTH-1:0] first_y_i,
  input  logic signed [VECTOR_WIDTH-1:0] first_z_i,
  input  logic signed [VECTOR_WIDTH-1:0] second_x_i,
  input  logic signed [VECTOR_WIDTH-1:0] second_y_i,
  input  logic signed [VECTOR_WIDTH-1:0] second_z_i,
  // result
  output logic                           result_valid_o,
  output logic signed [VECTOR_WIDTH-1:0] out_first_x_o,
  output logic signed [VECTOR_WIDTH-1:0] out_first_y_o,
  output logic signed [VECTOR_WIDTH-1:0] out_first_z_o,
  output logic signed [VECTOR_WIDTH-1:0] out_second_x_o,
  output logic signed [VECTOR_WIDTH-1:0] out_second_y_o,
  output logic signed [VECTOR_WIDTH-1:0] out_second_z_o,
  output logic                           saturated_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  // Rotated component, cross product, difference, crossed and final sums
  localparam int unsigned RW   = VECTOR_WIDTH + ROT_GROWTH;
  localparam int unsigned CPW  = RW + TRN_W;
  localparam int unsigned DW   = CPW + 1;
  localparam int unsigned CW   = DW - TRN_FRAC;
  localparam int unsigned RESW = CW + 1;
  localparam int unsigned NSTAGE = 5;

  localparam logic [VECTOR_WIDTH-1:0] SAT_MAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
  localparam logic [VECTOR_WIDTH-1:0] SAT_MIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  vector_kind_e          vector_kind_q;
  logic [ROT_ROW_W-1:0]  rot_row_q [3];
  logic [TRN_VEC_W-1:0]  trans_q;

  // Out-of-range indexes drop the write; wide data is truncated per register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_kind_q <= KIND_WRENCH;
      rot_row_q[0]  <= ROT_ROW_0_RESET;
      rot_row_q[1]  <= ROT_ROW_1_RESET;
      rot_row_q[2]  <= ROT_ROW_2_RESET;
      trans_q       <= TRANSLATION_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VECTOR_KIND: vector_kind_q <= vector_kind_e'(cfg_data_i[0]);
        CFG_ROT_ROW_0:   rot_row_q[0]  <= cfg_data_i[ROT_ROW_W-1:0];
        CFG_ROT_ROW_1:   rot_row_q[1]  <= cfg_data_i[ROT_ROW_W-1:0];
        CFG_ROT_ROW_2:   rot_row_q[2]  <= cfg_data_i[ROT_ROW_W-1:0];
        CFG_TRANSLATION: trans_q       <= cfg_data_i[TRN_VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid pipeline: bit s marks stage s+1 as holding a request
  // ---------------------------------------------------------------------------
  logic              accept;
  logic [NSTAGE-1:0] valid_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NSTAGE-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: rotate both halves of the vector
  // ---------------------------------------------------------------------------
  logic signed [VECTOR_WIDTH-1:0] vec_a [3];
  logic signed [VECTOR_WIDTH-1:0] vec_b [3];
  logic signed [RW-1:0]           rot_a [3];
  logic signed [RW-1:0]           rot_b [3];
  rot_en_t                        rot_en;

  assign vec_a[0] = first_x_i;
  assign vec_a[1] = first_y_i;
  assign vec_a[2] = first_z_i;
  assign vec_b[0] = second_x_i;
  assign vec_b[1] = second_y_i;
  assign vec_b[2] = second_z_i;

  assign rot_en.prod = accept;
  assign rot_en.sum  = valid_q[0];

  wtft_rotate #(
    .VECTOR_WIDTH (VECTOR_WIDTH)
  ) u_rotate_first (
    .clk_i     (clk_i),
    .en_i      (rot_en),
    .rot_row_i (rot_row_q),
    .vec_i     (vec_a),
    .rot_o     (rot_a)
  );

  wtft_rotate #(
    .VECTOR_WIDTH (VECTOR_WIDTH)
  ) u_rotate_second (
    .clk_i     (clk_i),
    .en_i      (rot_en),
    .rot_row_i (rot_row_q),
    .vec_i     (vec_b),
    .rot_o     (rot_b)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: cross-product partial products p x q.
  // The crossed vector q is also the half that passes straight through:
  // R f in wrench mode, R w in twist mode. The other half is the base that
  // receives the cross term.
  // ---------------------------------------------------------------------------
  logic signed [TRN_W-1:0] trn [3];
  logic signed [RW-1:0]    pass_d  [3];
  logic signed [RW-1:0]    base_d  [3];
  logic signed [RW-1:0]    pass3_q [3];
  logic signed [RW-1:0]    base3_q [3];
  logic signed [CPW-1:0]   cprod_d [6];
  logic signed [CPW-1:0]   cprod_q [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trn[k] = $signed(trans_q[TRN_W*k +: TRN_W]);
      if (vector_kind_q == KIND_WRENCH) begin
        pass_d[k] = rot_a[k];
        base_d[k] = rot_b[k];
      end else begin
        pass_d[k] = rot_b[k];
        base_d[k] = rot_a[k];
      end
    end
    // Pairs (minuend, subtrahend) for x, y, z
    cprod_d[0] = CPW'(trn[1]) * CPW'(pass_d[2]);
    cprod_d[1] = CPW'(trn[2]) * CPW'(pass_d[1]);
    cprod_d[2] = CPW'(trn[2]) * CPW'(pass_d[0]);
    cprod_d[3] = CPW'(trn[0]) * CPW'(pass_d[2]);
    cprod_d[4] = CPW'(trn[0]) * CPW'(pass_d[1]);
    cprod_d[5] = CPW'(trn[1]) * CPW'(pass_d[0]);
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[1]) begin
      pass3_q <= pass_d;
      base3_q <= base_d;
      cprod_q <= cprod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: cross difference, floored by 2^10
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] diff_d  [3];
  logic signed [CW-1:0] cross_q [3];
  logic signed [RW-1:0] pass4_q [3];
  logic signed [RW-1:0] base4_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_d[k] = DW'(cprod_q[2*k]) - DW'(cprod_q[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[2]) begin
      for (int k = 0; k < 3; k++) begin
        cross_q[k] <= $signed(diff_d[k][DW-1:TRN_FRAC]);
      end
      pass4_q <= pass3_q;
      base4_q <= base3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: add the cross term, route halves, saturate
  // ---------------------------------------------------------------------------
  logic signed [RESW-1:0]           res_d [6];
  logic signed [RESW-1:0]           sum_d [3];
  logic [RESW-VECTOR_WIDTH:0]       res_top [6];
  logic [5:0]                       clip_d;
  logic signed [VECTOR_WIDTH-1:0]   out_d [6];
  logic signed [VECTOR_WIDTH-1:0]   out_q [6];
  logic                             sat_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = RESW'(base4_q[k]) + RESW'(cross_q[k]);
      if (vector_kind_q == KIND_WRENCH) begin
        res_d[k]   = RESW'(pass4_q[k]);
        res_d[k+3] = sum_d[k];
      end else begin
        res_d[k]   = sum_d[k];
        res_d[k+3] = RESW'(pass4_q[k]);
      end
    end
    // Clip when the bits above the result's sign do not all match it
    for (int i = 0; i < 6; i++) begin
      res_top[i] = res_d[i][RESW-1:VECTOR_WIDTH-1];
      clip_d[i]  = (|res_top[i]) && !(&res_top[i]);
      if (clip_d[i]) begin
        out_d[i] = res_d[i][RESW-1] ? $signed(SAT_MIN) : $signed(SAT_MAX);
      end else begin
        out_d[i] = res_d[i][VECTOR_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[3]) begin
      out_q <= out_d;
      sat_q <= |clip_d;
    end
  end

  assign result_valid_o = valid_q[NSTAGE-1];
  assign out_first_x_o  = out_q[0];
  assign out_first_y_o  = out_q[1];
  assign out_first_z_o  = out_q[2];
  assign out_second_x_o = out_q[3];
  assign out_second_y_o = out_q[4];
  assign out_second_z_o = out_q[5];
  assign saturated_o    = sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic out_at_limit;

  always_comb begin
    out_at_limit = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if ((out_q[i] == $signed(SAT_MAX)) || (out_q[i] == $signed(SAT_MIN))) begin
        out_at_limit = 1'b1;
      end
    end
  end

  // Every request taken comes out as a result strobe
  a_request_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 result_valid_o)
    else $error("request did not produce a result after five cycles");

  // A clipped result carries at least one component at a range limit
  a_saturated_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |-> out_at_limit)
    else $error("saturated flag set with no component at a limit");

  // The result strobe never fires without a request in the stage before
  a_strobe_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(valid_q[NSTAGE-2]))
    else $error("result strobe without a request in flight");

endmodule

// File: test/tb_wrench_twist_frame_transform_core.sv
`timescale 1ns / 1ps

module tb_wrench_twist_frame_transform_core;
  import wtft_pkg::*;

  localparam int unsigned VW          = VECTOR_WIDTH_DEFAULT;
  // Register stages between an accepted request and its result
  localparam int unsigned PIPE_DEPTH  = 5;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 62;

  typedef logic signed [VW-1:0] component_t;

  // Six components in port order: first x/y/z, then second x/y/z
  typedef struct {
    component_t comp[6];
  } vector_t;

  typedef struct {
    component_t comp[6];
    logic       saturated;
  } transformed_t;

  localparam component_t COMP_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam component_t COMP_MIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [ROT_COEF_W-1:0] COEF_ONE     = 16'h4000;
  localparam logic [ROT_COEF_W-1:0] COEF_NEG_ONE = 16'hC000;
  localparam logic [ROT_COEF_W-1:0] COEF_MIN     = 16'h8000;
  localparam logic [ROT_COEF_W-1:0] COEF_MAX     = 16'h7FFF;
  localparam logic [TRN_W-1:0]      AXIS_MIN     = 20'h80000;
  localparam logic [TRN_W-1:0]      AXIS_MAX     = 20'h7FFFF;
  // One meter in 1/1024 m units
  localparam logic [TRN_W-1:0]      AXIS_ONE_M   = 20'd1024;

  // First register index past the defined ones; writes there must be dropped
  localparam int unsigned CFG_FIRST_UNUSED = int'(CFG_TRANSLATION) + 1;
  localparam int unsigned CFG_LAST_INDEX   = (1 << CFG_INDEX_W) - 1;

  // Shadow frame plus the queue of predicted transforms.
  class frame_scoreboard;
    vector_kind_e         kind;
    logic [ROT_ROW_W-1:0] rot_row[3];
    logic [TRN_VEC_W-1:0] offset;
    transformed_t         expected_vectors[$];
    string                field_name[6];
    int unsigned          mismatches;

    function new();
      kind       = KIND_WRENCH;
      rot_row[0] = ROT_ROW_0_RESET;
      rot_row[1] = ROT_ROW_1_RESET;
      rot_row[2] = ROT_ROW_2_RESET;
      offset     = TRANSLATION_RESET;
      mismatches = 0;
      field_name = '{"out_first_x", "out_first_y", "out_first_z",
                     "out_second_x", "out_second_y", "out_second_z"};
    endfunction

    // Drop upper data bits per register; ignore unused indexes.
    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_VECTOR_KIND: kind       = vector_kind_e'(data[0]);
        CFG_ROT_ROW_0:   rot_row[0] = data[ROT_ROW_W-1:0];
        CFG_ROT_ROW_1:   rot_row[1] = data[ROT_ROW_W-1:0];
        CFG_ROT_ROW_2:   rot_row[2] = data[ROT_ROW_W-1:0];
        CFG_TRANSLATION: offset     = data[TRN_VEC_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(sum r_k a_k / 2^14), exact: the sum stays below 2^50
    function longint rotate_row(logic [ROT_ROW_W-1:0] row, longint a0, longint a1, longint a2);
      longint acc;
      acc = longint'($signed(row[15:0]))  * a0
          + longint'($signed(row[31:16])) * a1
          + longint'($signed(row[47:32])) * a2;
      return acc >>> ROT_FRAC;
    endfunction

    // floor((pa qb - pb qa) / 2^10); products stay below 2^54
    function longint cross_term(longint pa, longint qb, longint pb, longint qa);
      return (pa * qb - pb * qa) >>> TRN_FRAC;
    endfunction

    function component_t clip_component(longint value, inout logic clipped);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (VW - 1)) - 1;
      lo = -hi - 1;
      if (value > hi) begin
        clipped = 1'b1;
        return COMP_MAX;
      end
      if (value < lo) begin
        clipped = 1'b1;
        return COMP_MIN;
      end
      return component_t'(value);
    endfunction

    function transformed_t transform_vector(vector_t v);
      longint       a[3];
      longint       b[3];
      longint       ra[3];
      longint       rb[3];
      longint       p[3];
      longint       q[3];
      longint       c[3];
      longint       total[6];
      transformed_t r;
      r.saturated = 1'b0;
      for (int k = 0; k < 3; k++) begin
        a[k] = v.comp[k];
        b[k] = v.comp[k+3];
        p[k] = longint'($signed(offset[TRN_W*k +: TRN_W]));
      end
      for (int k = 0; k < 3; k++) begin
        ra[k] = rotate_row(rot_row[k], a[0], a[1], a[2]);
        rb[k] = rotate_row(rot_row[k], b[0], b[1], b[2]);
      end
      // Lever arm acts on the rotated force (wrench) or angular rate (twist)
      if (kind == KIND_WRENCH) q = ra;
      else q = rb;
      c[0] = cross_term(p[1], q[2], p[2], q[1]);
      c[1] = cross_term(p[2], q[0], p[0], q[2]);
      c[2] = cross_term(p[0], q[1], p[1], q[0]);
      for (int k = 0; k < 3; k++) begin
        if (kind == KIND_WRENCH) begin
          total[k]   = ra[k];
          total[k+3] = rb[k] + c[k];
        end else begin
          total[k]   = ra[k] + c[k];
          total[k+3] = rb[k];
        end
      end
      for (int k = 0; k < 6; k++) r.comp[k] = clip_component(total[k], r.saturated);
      return r;
    endfunction

    function void note_request(vector_t v);
      expected_vectors.push_back(transform_vector(v));
    endfunction

    function void check_result(transformed_t got);
      transformed_t want;
      if (expected_vectors.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        mismatches++;
        return;
      end
      want = expected_vectors.pop_front();
      for (int k = 0; k < 6; k++) begin
        if (got.comp[k] !== want.comp[k]) begin
          $display("%0t: %s expected %0d, actual %0d",
                   $time, field_name[k], want.comp[k], got.comp[k]);
          mismatches++;
        end
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_vectors.size();
    endfunction
  endclass

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start_i        = 1'b0;
  logic                   busy_o;
  logic signed [VW-1:0]   first_x_i      = '0;
  logic signed [VW-1:0]   first_y_i      = '0;
  logic signed [VW-1:0]   first_z_i      = '0;
  logic signed [VW-1:0]   second_x_i     = '0;
  logic signed [VW-1:0]   second_y_i     = '0;
  logic signed [VW-1:0]   second_z_i     = '0;
  logic                   result_valid_o;
  logic signed [VW-1:0]   out_first_x_o;
  logic signed [VW-1:0]   out_first_y_o;
  logic signed [VW-1:0]   out_first_z_o;
  logic signed [VW-1:0]   out_second_x_o;
  logic signed [VW-1:0]   out_second_y_o;
  logic signed [VW-1:0]   out_second_z_o;
  logic                   saturated_o;
  logic                   cfg_we_i       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i     = '0;

  int unsigned     cycle_count;
  frame_scoreboard board = new();

  wrench_twist_frame_transform_core #(
    .VECTOR_WIDTH(VW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .first_x_i     (first_x_i),
    .first_y_i     (first_y_i),
    .first_z_i     (first_z_i),
    .second_x_i    (second_x_i),
    .second_y_i    (second_y_i),
    .second_z_i    (second_z_i),
    .result_valid_o(result_valid_o),
    .out_first_x_o (out_first_x_o),
    .out_first_y_o (out_first_y_o),
    .out_first_z_o (out_first_z_o),
    .out_second_x_o(out_second_x_o),
    .out_second_y_o(out_second_y_o),
    .out_second_z_o(out_second_z_o),
    .saturated_o   (saturated_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Observe every edge. All inputs are driven by nonblocking assignments and
  // all outputs are registered, so the values read here are the ones the
  // block sees at this edge: a config write, a request taken, a result
  // leaving the pipe.
  always @(posedge clk_i) begin : observe
    vector_t      seen;
    transformed_t got;
    if (cfg_we_i) board.set_register(cfg_index_i, cfg_data_i);
    if (start_i && !busy_o) begin
      seen.comp = '{first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i};
      board.note_request(seen);
    end
    if (result_valid_o) begin
      got.comp = '{out_first_x_o, out_first_y_o, out_first_z_o,
                   out_second_x_o, out_second_y_o, out_second_z_o};
      got.saturated = saturated_o;
      board.check_result(got);
    end
  end

  // Hold one request on the ports until the block takes it. Drop start
  // for gap cycles first when the sender is to pause.
  task automatic send_request(vector_t v, int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    first_x_i  <= v.comp[0];
    first_y_i  <= v.comp[1];
    first_z_i  <= v.comp[2];
    second_x_i <= v.comp[3];
    second_y_i <= v.comp[4];
    second_z_i <= v.comp[5];
    do @(posedge clk_i); while (busy_o);
  endtask

  // Lower start and wait for the next edge, so the next raise lands in a new step.
  task automatic stop_requests();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_frame(vector_kind_e kind, logic [ROT_ROW_W-1:0] row0,
                            logic [ROT_ROW_W-1:0] row1, logic [ROT_ROW_W-1:0] row2,
                            logic [TRN_VEC_W-1:0] offset);
    write_frame_reg(CFG_VECTOR_KIND, CFG_DATA_W'(kind));
    write_frame_reg(CFG_ROT_ROW_0, CFG_DATA_W'(row0));
    write_frame_reg(CFG_ROT_ROW_1, CFG_DATA_W'(row1));
    write_frame_reg(CFG_ROT_ROW_2, CFG_DATA_W'(row2));
    write_frame_reg(CFG_TRANSLATION, offset);
  endtask

  function automatic vector_t uniform_vector(component_t x);
    vector_t v;
    v.comp = '{default: x};
    return v;
  endfunction

  // Mix full-range words, extremes, tiny values and scaled-down values so
  // that results land both inside the range and beyond it.
  function automatic component_t random_component();
    component_t raw;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0: return raw;
      1: return COMP_MAX;
      2: return COMP_MIN;
      3: return component_t'($urandom_range(0, 2)) - 1;
      default: return raw >>> $urandom_range(4, 30);
    endcase
  endfunction

  function automatic vector_t random_vector();
    vector_t v;
    for (int k = 0; k < 6; k++) v.comp[k] = random_component();
    return v;
  endfunction

  function automatic logic [ROT_COEF_W-1:0] random_coef();
    logic signed [ROT_COEF_W-1:0] raw;
    raw = ROT_COEF_W'($urandom);
    case ($urandom_range(0, 4))
      0: return raw;
      1: return raw >>> $urandom_range(1, 15);
      2: return COEF_ONE;
      3: return COEF_NEG_ONE;
      default: return '0;
    endcase
  endfunction

  function automatic logic [ROT_ROW_W-1:0] random_row();
    return {random_coef(), random_coef(), random_coef()};
  endfunction

  function automatic logic [TRN_VEC_W-1:0] random_offset();
    logic signed [TRN_W-1:0] axis;
    logic [TRN_VEC_W-1:0]    packed_offset;
    for (int k = 0; k < 3; k++) begin
      axis = TRN_W'($urandom);
      axis = axis >>> $urandom_range(0, TRN_W - 1);
      packed_offset[TRN_W*k +: TRN_W] = axis;
    end
    return packed_offset;
  endfunction

  // Send a batch in bursts of random length. Bursty batches pause between
  // bursts; the others keep start high save while held. Hold the sender midway
  // until every outstanding result is back when asked.
  task automatic send_random_batch(int unsigned count, bit bursty, bit hold_midway);
    int unsigned left_in_burst;
    int unsigned gap;
    left_in_burst = 0;
    for (int unsigned n = 0; n < count; n++) begin
      gap = 0;
      if (left_in_burst == 0) begin
        left_in_burst = $urandom_range(1, 12);
        if (bursty) gap = $urandom_range(1, 6);
      end
      left_in_burst--;
      send_request(random_vector(), gap);
      if (hold_midway && n == count / 2) begin
        stop_requests();
        wait_for_results();
      end
    end
    stop_requests();
  endtask

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    vector_t v;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset frame: identity rotation, zero offset, wrench mode.
    send_request(uniform_vector('0), 0);
    send_request(uniform_vector(COMP_MAX), 0);
    send_request(uniform_vector(COMP_MIN), 0);
    send_request(uniform_vector('1), 0);
    v.comp = '{COMP_MAX, COMP_MIN, 1, -1, 32'h0001_0000, 32'hFFFF_0000};
    send_request(v, 0);
    stop_requests();
    wait_for_results();

    // Most negative coefficients and largest offset, twist mode: drive
    // both clipping directions.
    load_frame(KIND_TWIST, {3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}}, {3{AXIS_MAX}});
    v.comp = '{COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN};
    send_request(uniform_vector(COMP_MAX), 0);
    send_request(uniform_vector(COMP_MIN), 0);
    send_request(v, 0);
    send_request(uniform_vector(1), 0);
    stop_requests();
    wait_for_results();

    // Largest coefficients and most negative offset, wrench mode.
    load_frame(KIND_WRENCH, {3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}}, {3{AXIS_MIN}});
    send_request(uniform_vector(COMP_MAX), 0);
    send_request(uniform_vector(COMP_MIN), 0);
    send_request(v, 0);
    send_request(uniform_vector(1), 0);
    stop_requests();
    wait_for_results();

    // Unused register indexes: the frame must not change.
    for (int unsigned idx = CFG_FIRST_UNUSED; idx <= CFG_LAST_INDEX; idx++) begin
      write_frame_reg(CFG_INDEX_W'(idx), CFG_DATA_W'({$urandom, $urandom}));
    end
    // Data wider than the register: upper bits fall away, leaving wrench
    // mode and the identity rotation.
    write_frame_reg(CFG_VECTOR_KIND, 60'hFFF_FFFF_FFFF_FFFE);
    write_frame_reg(CFG_ROT_ROW_0, {12'hABC, ROT_ROW_0_RESET});
    write_frame_reg(CFG_ROT_ROW_1, {12'hFFF, ROT_ROW_1_RESET});
    write_frame_reg(CFG_ROT_ROW_2, {12'h555, ROT_ROW_2_RESET});
    write_frame_reg(CFG_TRANSLATION, {20'd512, AXIS_ONE_M, 20'hFFC00});
    v.comp = '{32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 0, 32'h0000_8000, -1};
    send_request(v, 0);
    send_request(uniform_vector(32'h0000_1234), 0);
    send_request(uniform_vector(COMP_MIN), 0);
    stop_requests();
    wait_for_results();
    write_frame_reg(CFG_VECTOR_KIND, CFG_DATA_W'(KIND_TWIST));
    send_request(v, 0);
    send_request(uniform_vector(32'hFFFF_EDCC), 0);
    send_request(uniform_vector(COMP_MAX), 0);
    stop_requests();
    wait_for_results();

    // Random frames: alternate the mode, vary the sender's pacing, and
    // hold the sender until the pipe drains in some phases.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      load_frame(vector_kind_e'(phase[0]), random_row(), random_row(), random_row(),
                 random_offset());
      send_random_batch(PHASE_ITEMS, (phase % 3) != 0, (phase % 4) == 1);
      wait_for_results();
    end

    // Allow any stray result to surface before deciding.
    repeat (4 * PIPE_DEPTH) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
